### rtl/ctq_pkg.sv
// ----------------------------------------------------------------------------
// ctq_pkg: shared types and codes of the coalescing timer queue
// Result beat layout, operation codes and result kind/status codes.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ENQUEUE  = 2'd1;
  localparam logic [1:0] OP_CANCEL   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] KIND_ENQ    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_ARM    = 2'd3;

  localparam logic [1:0] ST_FIRED     = 2'd0;
  localparam logic [1:0] ST_NEW       = 2'd1;
  localparam logic [1:0] ST_COALESCED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
  localparam logic [1:0] ST_MISSING   = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] handle;
    logic        arm_enable;
    logic [63:0] arm_delay;
    logic        last;
  } ctq_result_t;

endpackage

### rtl/coalescing_timer_queue.sv
// ----------------------------------------------------------------------------
// coalescing_timer_queue: timer table with slack coalescing
// Enqueue, cancel and tick operations over an event table and a handle table.
// ----------------------------------------------------------------------------
// One item at a time. Every table lookup is a sequential sweep through one
// compare unit with a single read port per table, one slot per cycle, with
// registered reads. Enqueue is at most one event sweep and cancel at most two
// handle sweeps; a stored enqueue, or a cancel of an event's last handle, then
// runs a flush. A flush runs one event sweep per retired event plus one and,
// per retired event, one handle sweep per expired handle plus one, then the
// arm command. The block stalls while the result register is held by the
// consumer. in_ready is high only while idle.
module coalescing_timer_queue #(
  parameter int EVENT_SLOTS  = 16,
  parameter int HANDLE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_now_time,
  input  logic [63:0] in_expiration_time,
  input  logic [63:0] in_late_tolerance,
  input  logic [63:0] in_early_tolerance,
  input  logic [31:0] in_cancel_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_handle,
  output logic        out_arm_enable,
  output logic [63:0] out_arm_delay,
  output logic        out_last
);
  import ctq_pkg::*;

  localparam int EW   = $clog2(EVENT_SLOTS);
  localparam int HW   = $clog2(HANDLE_SLOTS);
  localparam int MAXS = (EVENT_SLOTS > HANDLE_SLOTS) ? EVENT_SLOTS : HANDLE_SLOTS;
  localparam int CW   = $clog2(MAXS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WIN     = 4'd1;
  localparam logic [3:0] S_WIN2    = 4'd2;
  localparam logic [3:0] S_EQ_SCAN = 4'd3;
  localparam logic [3:0] S_EQ_DEC  = 4'd4;
  localparam logic [3:0] S_FL_SCAN = 4'd5;
  localparam logic [3:0] S_FL_CHK  = 4'd6;
  localparam logic [3:0] S_ARM     = 4'd7;
  localparam logic [3:0] S_H_SCAN  = 4'd8;
  localparam logic [3:0] S_H_CHK   = 4'd9;
  localparam logic [3:0] S_CF_SCAN = 4'd10;
  localparam logic [3:0] S_CF_CHK  = 4'd11;
  localparam logic [3:0] S_CC_SCAN = 4'd12;
  localparam logic [3:0] S_CC_DEC  = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  logic [3:0]  state_r, ret_r;
  logic [63:0] max_delay_r;
  logic [63:0] now_r, exp_r, late_tol_r, early_tol_r, early_r, late_r, diff_r;
  logic [31:0] want_r, hcnt_r;
  logic [EVENT_SLOTS-1:0]  ev_valid_r;
  logic [HANDLE_SLOTS-1:0] hv_r;
  logic [CW-1:0] scan_r;
  logic [CW-1:0] scan_m1;
  logic [EW-1:0] p_ev, ev_addr;
  logic [HW-1:0] p_h, h_addr;

  // sweep results
  logic          bf_r, mf_r, ff_r, pf_r;
  logic [EW-1:0] best_r, match_r, free_ev_r, pick_slot_r;
  logic [63:0]   best_t_r, match_t_r;
  logic [HW-1:0] pick_r;
  logic [31:0]   pick_num_r, pick_age_r, age;
  logic [1:0]    cnt_r;

  // table storage
  logic [63:0]   ev_mem [EVENT_SLOTS];
  logic [31:0]   hn_mem [HANDLE_SLOTS];
  logic [EW-1:0] hs_mem [HANDLE_SLOTS];
  logic [63:0]   ev_rd_r;
  logic [31:0]   hn_rd_r;
  logic [EW-1:0] hs_rd_r;

  logic          freeh_found;
  logic [HW-1:0] freeh_idx;
  logic          eq_ok;
  logic [EW-1:0] eq_slot;
  logic          ev_we, h_we;
  logic          in_fire, scan_state, ev_end, h_end;

  ctq_result_t em_r;
  logic        em_load, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign em_load   = (state_r == S_EMIT) && out_free;

  assign scan_m1 = scan_r - 1'b1;
  assign p_ev    = scan_m1[EW-1:0];
  assign p_h     = scan_m1[HW-1:0];
  assign ev_addr = (scan_r < CW'(EVENT_SLOTS)) ? scan_r[EW-1:0] : '0;
  assign h_addr  = (scan_r < CW'(HANDLE_SLOTS)) ? scan_r[HW-1:0] : '0;
  assign ev_end  = (scan_r == CW'(EVENT_SLOTS));
  assign h_end   = (scan_r == CW'(HANDLE_SLOTS));
  assign age     = hcnt_r - hn_rd_r;

  assign scan_state = (state_r == S_EQ_SCAN) || (state_r == S_FL_SCAN) ||
                      (state_r == S_H_SCAN) || (state_r == S_CF_SCAN) ||
                      (state_r == S_CC_SCAN);

  always_comb begin
    freeh_found = 1'b0;
    freeh_idx   = '0;
    for (int h = HANDLE_SLOTS - 1; h >= 0; h--) begin
      if (!hv_r[h]) begin
        freeh_found = 1'b1;
        freeh_idx   = HW'(h);
      end
    end
  end

  assign eq_ok   = freeh_found && (mf_r || ff_r);
  assign eq_slot = mf_r ? match_r : free_ev_r;
  assign ev_we   = (state_r == S_EQ_DEC) && eq_ok && !mf_r;
  assign h_we    = (state_r == S_EQ_DEC) && eq_ok;

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[eq_slot] <= exp_r;
    end
    if (h_we) begin
      hn_mem[freeh_idx] <= hcnt_r;
      hs_mem[freeh_idx] <= eq_slot;
    end
    ev_rd_r <= ev_mem[ev_addr];
    hn_rd_r <= hn_mem[h_addr];
    hs_rd_r <= hs_mem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      max_delay_r <= '1;
      ev_valid_r  <= '0;
      hv_r        <= '0;
      hcnt_r      <= '0;
      scan_r      <= '0;
      bf_r        <= 1'b0;
      mf_r        <= 1'b0;
      ff_r        <= 1'b0;
      pf_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        max_delay_r <= cfg_data;
      end
      // restart the sweep machinery whenever outside a sweep
      if (!scan_state) begin
        scan_r <= '0;
        bf_r   <= 1'b0;
        mf_r   <= 1'b0;
        ff_r   <= 1'b0;
        pf_r   <= 1'b0;
        cnt_r  <= '0;
      end else begin
        scan_r <= scan_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r       <= in_now_time;
            exp_r       <= in_expiration_time;
            late_tol_r  <= in_late_tolerance;
            early_tol_r <= in_early_tolerance;
            want_r      <= in_cancel_handle;
            case (in_operation)
              OP_TICK:    state_r <= S_FL_SCAN;
              OP_ENQUEUE: state_r <= S_WIN;
              OP_CANCEL:  state_r <= S_CF_SCAN;
              default:    state_r <= S_IDLE;
            endcase
          end
        end
        S_WIN: begin
          early_r <= (exp_r >= early_tol_r) ? exp_r - early_tol_r : '0;
          late_r  <= (~exp_r >= late_tol_r) ? exp_r + late_tol_r : '1;
          state_r <= S_WIN2;
        end
        S_WIN2: begin
          if (now_r >= early_r) begin
            em_r    <= '{KIND_ENQ, ST_FIRED, 32'd0, 1'b0, 64'd0, 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_EQ_SCAN;
          end
        end
        S_EQ_SCAN: begin
          if (scan_r != '0) begin
            if (!ev_valid_r[p_ev]) begin
              if (!ff_r) begin
                ff_r      <= 1'b1;
                free_ev_r <= p_ev;
              end
            end else if (ev_rd_r >= early_r && ev_rd_r <= late_r &&
                         (!mf_r || ev_rd_r < match_t_r)) begin
              mf_r      <= 1'b1;
              match_r   <= p_ev;
              match_t_r <= ev_rd_r;
            end
          end
          if (ev_end) begin
            state_r <= S_EQ_DEC;
          end
        end
        S_EQ_DEC: begin
          if (!eq_ok) begin
            em_r  <= '{KIND_ENQ, ST_FULL, 32'd0, 1'b0, 64'd0, 1'b1};
            ret_r <= S_IDLE;
          end else begin
            if (!mf_r) begin
              ev_valid_r[eq_slot] <= 1'b1;
            end
            hv_r[freeh_idx] <= 1'b1;
            hcnt_r          <= hcnt_r + 32'd1;
            em_r  <= '{KIND_ENQ, mf_r ? ST_COALESCED : ST_NEW, hcnt_r, 1'b0, 64'd0, 1'b0};
            ret_r <= S_FL_SCAN;
          end
          state_r <= S_EMIT;
        end
        S_FL_SCAN: begin
          if (scan_r != '0 && ev_valid_r[p_ev] && (!bf_r || ev_rd_r < best_t_r)) begin
            bf_r     <= 1'b1;
            best_r   <= p_ev;
            best_t_r <= ev_rd_r;
          end
          if (ev_end) begin
            state_r <= S_FL_CHK;
          end
        end
        S_FL_CHK: begin
          if (bf_r && best_t_r <= now_r) begin
            state_r <= S_H_SCAN;
          end else if (bf_r) begin
            diff_r  <= best_t_r - now_r;
            state_r <= S_ARM;
          end else begin
            em_r    <= '{KIND_ARM, ST_NONE, 32'd0, 1'b0, 64'd0, 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end
        end
        S_ARM: begin
          em_r <= '{KIND_ARM, ST_NONE, 32'd0, 1'b1,
                    (diff_r > max_delay_r) ? max_delay_r : diff_r, 1'b1};
          ret_r   <= S_IDLE;
          state_r <= S_EMIT;
        end
        S_H_SCAN: begin
          // oldest handle of the due event goes first
          if (scan_r != '0 && hv_r[p_h] && hs_rd_r == best_r &&
              (!pf_r || age > pick_age_r)) begin
            pf_r       <= 1'b1;
            pick_r     <= p_h;
            pick_age_r <= age;
            pick_num_r <= hn_rd_r;
          end
          if (h_end) begin
            state_r <= S_H_CHK;
          end
        end
        S_H_CHK: begin
          if (pf_r) begin
            hv_r[pick_r] <= 1'b0;
            em_r    <= '{KIND_EXPIRE, ST_NONE, pick_num_r, 1'b0, 64'd0, 1'b0};
            ret_r   <= S_H_SCAN;
            state_r <= S_EMIT;
          end else begin
            ev_valid_r[best_r] <= 1'b0;
            state_r            <= S_FL_SCAN;
          end
        end
        S_CF_SCAN: begin
          if (scan_r != '0 && hv_r[p_h] && hn_rd_r == want_r && !pf_r) begin
            pf_r        <= 1'b1;
            pick_r      <= p_h;
            pick_slot_r <= hs_rd_r;
          end
          if (h_end) begin
            state_r <= S_CF_CHK;
          end
        end
        S_CF_CHK: begin
          if (pf_r) begin
            state_r <= S_CC_SCAN;
          end else begin
            em_r    <= '{KIND_CANCEL, ST_MISSING, want_r, 1'b0, 64'd0, 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end
        end
        S_CC_SCAN: begin
          // count handles sharing the event, saturate at two
          if (scan_r != '0 && hv_r[p_h] && hs_rd_r == pick_slot_r && cnt_r != 2'd2) begin
            cnt_r <= cnt_r + 2'd1;
          end
          if (h_end) begin
            state_r <= S_CC_DEC;
          end
        end
        S_CC_DEC: begin
          hv_r[pick_r] <= 1'b0;
          if (cnt_r == 2'd1) begin
            ev_valid_r[pick_slot_r] <= 1'b0;
            em_r  <= '{KIND_CANCEL, ST_DONE, want_r, 1'b0, 64'd0, 1'b0};
            ret_r <= S_FL_SCAN;
          end else begin
            em_r  <= '{KIND_CANCEL, ST_DONE, want_r, 1'b0, 64'd0, 1'b1};
            ret_r <= S_IDLE;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ctq_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (em_load),
    .load_data      (em_r),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_handle     (out_handle),
    .out_arm_enable (out_arm_enable),
    .out_arm_delay  (out_arm_delay),
    .out_last       (out_last)
  );

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_operation == OP_TICK || in_operation == OP_ENQUEUE ||
                in_operation == OP_CANCEL) |=> state_r != S_IDLE)
    else $error("accepted operation did not start");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    em_load && em_r.last |-> ret_r == S_IDLE)
    else $error("final beat sent while item still in progress");

  a_one_handle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> $countones(hv_r ^ $past(hv_r)) <= 1)
    else $error("more than one handle slot changed in a cycle");

endmodule

### rtl/ctq_out_reg.sv
// ----------------------------------------------------------------------------
// ctq_out_reg: result output register
// Holds one result beat until the consumer takes it; reports when free.
// ----------------------------------------------------------------------------
module ctq_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ctq_pkg::ctq_result_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [1:0]          out_status,
  output logic [31:0]         out_handle,
  output logic                out_arm_enable,
  output logic [63:0]         out_arm_delay,
  output logic                out_last
);
  import ctq_pkg::*;

  logic        valid_r;
  ctq_result_t data_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = data_r.kind;
  assign out_status     = data_r.status;
  assign out_handle     = data_r.handle;
  assign out_arm_enable = data_r.arm_enable;
  assign out_arm_delay  = data_r.arm_delay;
  assign out_last       = data_r.last;

endmodule
